### rtl/cpa_trend_window_monitor_defines.svh
// Assertion macros for the CPA trend window monitor.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef CPA_TREND_WINDOW_MONITOR_DEFINES_SVH
`define CPA_TREND_WINDOW_MONITOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CPA_TW_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPA_TW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/cpa_tw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the CPA trend window monitor.
// No dependencies; used by cpa_tw_div and cpa_trend_window_monitor.
package cpa_tw_pkg;

  localparam int unsigned DEPTH     = 30;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned Q_W       = 22;
  localparam int unsigned M_W       = 25;
  localparam int unsigned CLOSE_W   = 8;
  localparam int unsigned SLOPE_W   = 32;
  localparam int unsigned DIV_W     = 33;
  localparam int unsigned DSR_W     = 11;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_A_W   = 2;
  localparam int unsigned RECIP_W   = 32;
  localparam int unsigned CONV_SH   = 34;

  localparam logic [DSR_W-1:0]   NM_METRES      = 11'd1852;
  // ceil(2^34 * 256 / 1852): metres times this, shifted down by CONV_SH, is
  // floor(metres * 256 / 1852) over the whole 25-bit range
  localparam logic [RECIP_W-1:0] NM_RECIP       = 32'd2374755136;
  localparam logic [Q_W-1:0]     EMPTY_FRAME_Q8 = 22'd2559744;
  localparam logic [CLOSE_W-1:0] MAX_CLOSE      = 8'd255;
  localparam logic [CLOSE_W-1:0] LIMIT_RESET    = 8'd2;

  localparam logic [CFG_A_W-1:0] REG_SLOPE_THR  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_NEAR_DIST  = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_NEAR_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    CMD_TARGET = 2'd0,
    CMD_EOF    = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_WALK,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/cpa_trend_window_monitor.sv
`timescale 1ns / 1ps
// CPA trend window monitor: per-frame CPA minimum, 30-frame history, trend slope.
// The block is used as follows.
//   Input stream: tuser carries the command (target reading, end of frame, clear
//   history); tdata carries the target CPA in metres. Output stream: one
//   transaction per end of frame with slope, degrading flag, window max and
//   close-target count. Config: write enable, register index, data; write only
//   while the block is idle.
//   Flow: one item at a time. For a target reading the metres value is
//   registered, then scaled to Q14.8 nautical miles by a reciprocal multiply.
//   An end of frame runs a walk over the stored entries through the
//   single-port history memory, then, when at least two entries are stored,
//   the 33-step divider for the slope, then the output register load.
//   The output register decouples the sides: tready returns while a result
//   still waits; if the receiver stalls, the next end of frame holds in its
//   final step until the register frees.
//   Reset clears the history pointers, frame accumulators, configuration
//   registers and output valid; the history memory needs no clearing pass since only written entries are read.
// Depends on cpa_tw_pkg, cpa_tw_div and cpa_trend_window_monitor_defines.svh.
`include "cpa_trend_window_monitor_defines.svh"

module cpa_trend_window_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [cpa_tw_pkg::CFG_A_W-1:0] cfg_addr_i,
  input  logic [cpa_tw_pkg::CFG_W-1:0]   cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // [24:0] target_cpa_m
  input  logic [1:0]                    s_axis_tuser,  // [1:0] command
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] trend_degrading, [32:1] trend_slope, [54:33] window_max_nm,
  // [55] many_nearby, [63:56] close_targets
  output logic [63:0]                   m_axis_tdata
);
  import cpa_tw_pkg::*;

  // configuration
  logic signed [SLOPE_W-1:0]   thr_q;
  logic [Q_W+DSR_W-1:0]        near_m_q;
  logic [CLOSE_W-1:0]          limit_q;

  // history and frame state
  logic [Q_W-1:0]   ring_mem [DEPTH];
  logic [Q_W-1:0]   rd_data_q;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [Q_W-1:0]   fmin_q;
  logic             fhas_q;
  logic [CLOSE_W-1:0] fclose_q;

  // end-of-frame working registers
  logic [Q_W-1:0]   newest_q, oldest_q, wmax_q;
  logic [PTR_W-1:0] oldest_idx_q;
  logic [CNT_W-1:0] walk_idx_q;
  logic [PTR_W-1:0] rd_idx_q;
  logic             rd_pend_q;
  logic             neg_q;
  logic signed [SLOPE_W-1:0] slope_q;
  logic [M_W-1:0]   conv_m_q;

  state_e state_q, state_d;

  logic             accept;
  logic             rd_en;
  logic             walk_done;
  logic             load_out;
  logic             m_valid_q;
  logic [63:0]      m_data_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [DIV_W-1:0]       conv_dvd;
  logic                   close_hit;
  logic [M_W+RECIP_W-1:0] conv_prod;
  logic [Q_W-1:0]         conv_q8;
  logic [Q_W-1:0]         stored;
  logic signed [Q_W:0]    diff;
  logic [Q_W:0]           diff_abs;
  logic [SLOPE_W-1:0]     quot32;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign conv_dvd  = {s_axis_tdata[M_W-1:0], 8'd0};
  assign close_hit = conv_dvd < near_m_q;
  assign stored    = fhas_q ? fmin_q : EMPTY_FRAME_Q8;
  assign rd_en     = (state_q == S_WALK) && (walk_idx_q < fill_q);
  assign walk_done = (state_q == S_WALK) && !rd_en && !rd_pend_q;
  assign diff      = $signed({1'b0, newest_q}) - $signed({1'b0, oldest_q});
  assign diff_abs  = diff[Q_W] ? (Q_W+1)'(-diff) : diff;
  assign quot32    = div_rsp.quotient[SLOPE_W-1:0];
  // top product bit set means the Q14.8 value overflows 22 bits: saturate
  assign conv_prod = conv_m_q * NM_RECIP;
  assign conv_q8   = conv_prod[M_W+RECIP_W-1] ? {Q_W{1'b1}}
                                              : conv_prod[CONV_SH+Q_W-1:CONV_SH];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            CMD_TARGET: state_d = S_CONV;
            CMD_EOF:    state_d = S_WALK;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_CONV: state_d = S_IDLE;
      S_WALK: begin
        if (walk_done) state_d = (fill_q >= CNT_W'(2)) ? S_DIV : S_OUT;
      end
      S_DIV:  if (div_rsp.done) state_d = S_OUT;
      S_OUT:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready    = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = conv_dvd;
    div_req.divisor  = NM_METRES;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      S_WALK: begin
        div_req.start    = walk_done && (fill_q >= CNT_W'(2));
        div_req.dividend = {{(DIV_W-Q_W-8){1'b0}}, diff_abs[Q_W-1:0], 8'd0};
        div_req.divisor  = DSR_W'(fill_q - 1'b1);
      end
      S_OUT:   load_out = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      near_m_q <= '0;
      limit_q  <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SLOPE_THR:  thr_q    <= cfg_wdata_i;
        REG_NEAR_DIST:  near_m_q <= cfg_wdata_i[Q_W-1:0] * NM_METRES;
        REG_NEAR_LIMIT: limit_q  <= cfg_wdata_i[CLOSE_W-1:0];
        default: ;
      endcase
    end
  end

  // history pointers
  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (accept && (s_axis_tuser == CMD_CLEAR)) begin
      wp_d   = '0;
      fill_d = '0;
    end else if (accept && (s_axis_tuser == CMD_EOF)) begin
      wp_d = (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (fill_q < CNT_W'(DEPTH)) fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

  // history memory, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (accept && (s_axis_tuser == CMD_EOF)) ring_mem[wp_q] <= stored;
    if (rd_en) rd_data_q <= ring_mem[walk_idx_q[PTR_W-1:0]];
  end

  // frame accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmin_q   <= '0;
      fhas_q   <= 1'b0;
      fclose_q <= '0;
    end else if (load_out) begin
      fmin_q   <= '0;
      fhas_q   <= 1'b0;
      fclose_q <= '0;
    end else if (state_q == S_CONV) begin
      if (!fhas_q || conv_q8 < fmin_q) fmin_q <= conv_q8;
      fhas_q <= 1'b1;
    end else if (accept && (s_axis_tuser == CMD_TARGET)) begin
      if (close_hit && fclose_q != MAX_CLOSE) fclose_q <= fclose_q + 1'b1;
    end
  end

  // walk over the stored entries: window max and oldest entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_idx_q <= '0;
      rd_pend_q  <= 1'b0;
    end else begin
      rd_pend_q <= rd_en;
      if (accept) walk_idx_q <= '0;
      else if (rd_en) walk_idx_q <= walk_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (s_axis_tuser == CMD_TARGET)) conv_m_q <= s_axis_tdata[M_W-1:0];
    if (accept && (s_axis_tuser == CMD_EOF)) begin
      newest_q     <= stored;
      oldest_idx_q <= (fill_d < CNT_W'(DEPTH)) ? '0 : wp_d;
      wmax_q       <= '0;
      slope_q      <= '0;
    end
    if (rd_en) rd_idx_q <= walk_idx_q[PTR_W-1:0];
    if (rd_pend_q) begin
      if (rd_data_q > wmax_q) wmax_q <= rd_data_q;
      if (rd_idx_q == oldest_idx_q) oldest_q <= rd_data_q;
    end
    if (div_req.start && state_q == S_WALK) neg_q <= diff[Q_W];
    // negate the magnitude for a truncate-toward-zero quotient
    if (state_q == S_DIV && div_rsp.done) slope_q <= neg_q ? -quot32 : quot32;
  end

  cpa_tw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {fclose_q, (fclose_q >= limit_q), wmax_q, slope_q, (slope_q < thr_q)};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `CPA_TW_ASSERT_NEXT(a_eof_busy, accept && (s_axis_tuser == CMD_EOF), !s_axis_tready, "ready right after end of frame")
  `CPA_TW_ASSERT_NOW(a_fill_range, 1'b1, (fill_q <= CNT_W'(DEPTH)) && (wp_q < PTR_W'(DEPTH)), "history pointer out of range")
  `CPA_TW_ASSERT_NOW(a_div_done_state, div_rsp.done, state_q == S_DIV, "divider finished outside the slope step")

endmodule

### rtl/cpa_tw_div.sv
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on cpa_tw_pkg for widths and the request/response structs.
module cpa_tw_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpa_tw_pkg::div_req_t req_i,
  output cpa_tw_pkg::div_rsp_t rsp_o
);
  import cpa_tw_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [DSR_W-1:0]     rem_q, rem_d;
  logic [DSR_W-1:0]     dsr_q, dsr_d;
  logic [DSR_W:0]       rem_sh;
  logic [DSR_W:0]       rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W - 1);
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in one quotient bit, keep the partial remainder below the divisor
      dvd_d = {dvd_q[DIV_W-2:0], ge};
      rem_d = ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule
